/* rtl/pdtc_pkg.sv */
// pdtc_pkg: widths, register indexes, mode codes, reset values and pipeline beat types
// for the pid drive/turn controller; no dependencies
`timescale 1ns / 1ps

package pdtc_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int GAIN_W     = 24;
    localparam int SENSOR_W   = 16;
    localparam int MODE_W     = 2;
    localparam int LIMIT_W    = 7;
    localparam int POWER_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SENSED_W = SENSOR_W + 1;
    localparam int ERR_W    = SENSOR_W + 2;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int DIFF_W   = SENSOR_W + 1;
    localparam int ISUM_W   = 32;
    localparam int QUOT_W   = LIMIT_W + FRAC_BITS;

    localparam int P_PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int I_PROD_W     = GAIN_W + 1 + ISUM_W;
    localparam int D_PROD_W     = GAIN_W + 1 + DERIV_W;
    localparam int DRIFT_PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int PIDSUM_W     = I_PROD_W + 2;
    localparam int PID_W        = 16 + FRAC_BITS;
    localparam int SIDE_W       = DRIFT_PROD_W + 2;

    localparam int MAX_DRIVE_DEFAULT = 127;
    localparam int POWER_LIMIT       = 127;

    localparam logic [MODE_W-1:0]  MODE_RESET   = 2'd0;
    localparam logic [SENSOR_W-1:0] TARGET_RESET = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_P_RESET = 24'd104858;
    localparam logic [GAIN_W-1:0]  GAIN_I_RESET = 24'd10;
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET = 24'd0;
    localparam logic [GAIN_W-1:0]  GAIN_DRIFT_RESET = 24'd524288;
    localparam logic [LIMIT_W-1:0] ILIMIT_RESET = 7'd50;

    localparam logic [MODE_W-1:0] MODE_DRIVE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TURN_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TURN_RIGHT = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_TARGET     = 3'd1,
        CFG_GAIN_P     = 3'd2,
        CFG_GAIN_I     = 3'd3,
        CFG_GAIN_D     = 3'd4,
        CFG_GAIN_DRIFT = 3'd5,
        CFG_ILIMIT     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [SENSOR_W-1:0] target;
        logic [GAIN_W-1:0]          gain_p;
        logic [GAIN_W-1:0]          gain_i;
        logic [GAIN_W-1:0]          gain_d;
        logic [GAIN_W-1:0]          gain_drift;
        logic [LIMIT_W-1:0]         ilimit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [ISUM_W-1:0]  isum;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [DIFF_W-1:0]  diff;
        logic                      turning;
        logic                      turn_left;
        logic                      at_target;
    } err_beat_t;

    typedef struct packed {
        logic signed [P_PROD_W-1:0]     p_term;
        logic signed [I_PROD_W-1:0]     i_term;
        logic signed [D_PROD_W-1:0]     d_term;
        logic signed [DRIFT_PROD_W-1:0] drift;
        logic                           turning;
        logic                           turn_left;
        logic                           at_target;
    } prod_beat_t;

endpackage

/* rtl/pdtc_clamp_div.sv */
// pdtc_clamp_div: bit-serial restoring divider giving floor((limit << FRAC_BITS) / gain_i),
// the integral sum bound; depends on pdtc_pkg
`timescale 1ns / 1ps

module pdtc_clamp_div
    import pdtc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [LIMIT_W-1:0] limit,
    input  logic [GAIN_W-1:0]  gain,
    output logic               busy,
    output logic [QUOT_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [GAIN_W-1:0] rem_reg,  rem_next;
    logic [QUOT_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic [GAIN_W:0]   rem_shift;
    logic              fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[QUOT_W-1]};
        fits      = rem_shift >= {1'b0, gain};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = {limit, {FRAC_BITS{1'b0}}};
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? GAIN_W'(rem_shift - {1'b0, gain}) : GAIN_W'(rem_shift);
            quo_next  = {quo_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/pdtc_error_stage.sv */
// pdtc_error_stage: error, integral zone and clamp, derivative and drift difference;
// holds the integral sum and last error; depends on pdtc_pkg
`timescale 1ns / 1ps

module pdtc_error_stage
    import pdtc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       accept,
    input  cfg_t                       cfg,
    input  logic [QUOT_W-1:0]          clamp_quot,
    input  logic                       s_restart,
    input  logic signed [SENSOR_W-1:0] s_primary_sensor,
    input  logic signed [SENSOR_W-1:0] s_secondary_sensor,
    output logic                       valid_o,
    output err_beat_t                  beat_o
);

    localparam int E8_W = ERR_W + 3;

    logic signed [ISUM_W-1:0] isum_reg, isum_next;
    logic signed [ERR_W-1:0]  prev_reg;
    logic                     valid_reg;
    err_beat_t                beat_reg, beat_next;

    logic                       turning;
    logic signed [SENSED_W-1:0] prim;
    logic signed [SENSED_W-1:0] sensed;
    logic signed [SENSED_W-1:0] tgt_s;
    logic signed [ERR_W-1:0]    err;
    logic signed [E8_W-1:0]     e8, e8_abs, tgt8;
    logic signed [ISUM_W-1:0]   base_sum, sum_sat, quot_s;
    logic signed [ERR_W-1:0]    base_prev;
    logic signed [ISUM_W:0]     sum_wide;

    always_comb begin
        turning   = cfg.mode == MODE_TURN_LEFT || cfg.mode == MODE_TURN_RIGHT;
        prim      = SENSED_W'(s_primary_sensor);
        sensed    = (turning && prim < 0) ? -prim : prim;
        tgt_s     = SENSED_W'($signed(cfg.target));
        err       = ERR_W'($signed(cfg.target)) - ERR_W'(sensed);
        e8        = $signed({err, 3'b000});
        e8_abs    = (e8 < 0) ? -e8 : e8;
        tgt8      = E8_W'($signed(cfg.target));
        base_sum  = s_restart ? '0 : isum_reg;
        base_prev = s_restart ? '0 : prev_reg;

        sum_wide = (ISUM_W + 1)'(base_sum);
        if (turning) begin
            if (e8 < tgt8) begin
                sum_wide = (ISUM_W + 1)'(base_sum) + (ISUM_W + 1)'(err);
            end else if (e8 > tgt8) begin
                sum_wide = '0;
            end
        end else begin
            if (e8_abs < tgt8) begin
                sum_wide = (ISUM_W + 1)'(base_sum) + (ISUM_W + 1)'(err);
            end else begin
                sum_wide = '0;
            end
        end

        if (sum_wide[ISUM_W] != sum_wide[ISUM_W-1]) begin
            sum_sat = sum_wide[ISUM_W] ? $signed({1'b1, {(ISUM_W-1){1'b0}}})
                                       : $signed({1'b0, {(ISUM_W-1){1'b1}}});
        end else begin
            sum_sat = sum_wide[ISUM_W-1:0];
        end

        // bound is floor((limit << FRAC_BITS) / gain_i), so the compare matches the product test
        quot_s    = $signed({{(ISUM_W-QUOT_W){1'b0}}, clamp_quot});
        isum_next = sum_sat;
        if (cfg.gain_i != '0) begin
            if (sum_sat > quot_s) begin
                isum_next = quot_s;
            end else if (sum_sat < -quot_s) begin
                isum_next = -quot_s;
            end
        end

        beat_next.err       = err;
        beat_next.isum      = isum_next;
        beat_next.deriv     = DERIV_W'(err) - DERIV_W'(base_prev);
        beat_next.diff      = DIFF_W'(s_primary_sensor) - DIFF_W'(s_secondary_sensor);
        beat_next.turning   = turning;
        beat_next.turn_left = cfg.mode == MODE_TURN_LEFT;
        beat_next.at_target = sensed == tgt_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isum_reg  <= '0;
            prev_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                isum_reg <= isum_next;
                prev_reg <= err;
            end
            if (adv) begin
                valid_reg <= accept;
            end
        end
        if (adv) begin
            beat_reg <= beat_next;
        end
    end

    assign valid_o = valid_reg;
    assign beat_o  = beat_reg;

endmodule

/* rtl/pdtc_product_stage.sv */
// pdtc_product_stage: the four gain products, one multiplier each, registered;
// depends on pdtc_pkg
`timescale 1ns / 1ps

module pdtc_product_stage
    import pdtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  cfg_t       cfg,
    input  logic       valid_i,
    input  err_beat_t  beat_i,
    output logic       valid_o,
    output prod_beat_t beat_o
);

    logic       valid_reg;
    prod_beat_t beat_reg, beat_next;

    always_comb begin
        beat_next.p_term    = $signed({1'b0, cfg.gain_p}) * beat_i.err;
        beat_next.i_term    = $signed({1'b0, cfg.gain_i}) * beat_i.isum;
        beat_next.d_term    = $signed({1'b0, cfg.gain_d}) * beat_i.deriv;
        beat_next.drift     = $signed({1'b0, cfg.gain_drift}) * beat_i.diff;
        beat_next.turning   = beat_i.turning;
        beat_next.turn_left = beat_i.turn_left;
        beat_next.at_target = beat_i.at_target;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
        if (adv) begin
            beat_reg <= beat_next;
        end
    end

    assign valid_o = valid_reg;
    assign beat_o  = beat_reg;

endmodule

/* rtl/pdtc_mix_stage.sv */
// pdtc_mix_stage: pid sum and clamp, side mixing, truncation and output saturation,
// ending in the result register; depends on pdtc_pkg
`timescale 1ns / 1ps

module pdtc_mix_stage
    import pdtc_pkg::*;
#(
    parameter int MAX_DRIVE = MAX_DRIVE_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      valid_i,
    input  prod_beat_t                beat_i,
    output logic                      m_valid,
    output logic signed [POWER_W-1:0] m_left_power,
    output logic signed [POWER_W-1:0] m_right_power,
    output logic                      m_at_target
);

    localparam int WHOLE_W = SIDE_W - FRAC_BITS;
    localparam longint PID_LIM_I = longint'(MAX_DRIVE) * (longint'(1) << FRAC_BITS);
    localparam logic signed [PIDSUM_W-1:0] PID_LIM = PIDSUM_W'(PID_LIM_I);
    localparam logic signed [SIDE_W-1:0] ROUND_BIAS =
        SIDE_W'((longint'(1) << FRAC_BITS) - 1);
    localparam logic signed [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(POWER_LIMIT);

    function automatic logic signed [POWER_W-1:0] to_power(
        input logic signed [SIDE_W-1:0] x
    );
        logic signed [SIDE_W-1:0]  biased;
        logic signed [WHOLE_W-1:0] whole;
        biased = x[SIDE_W-1] ? x + ROUND_BIAS : x;
        whole  = biased[SIDE_W-1:FRAC_BITS];
        if (whole > WHOLE_MAX) begin
            whole = WHOLE_MAX;
        end else if (whole < -WHOLE_MAX) begin
            whole = -WHOLE_MAX;
        end
        return POWER_W'(whole);
    endfunction

    // pid stage
    logic                           pid_valid_reg;
    logic signed [PID_W-1:0]        pid_reg;
    logic signed [DRIFT_PROD_W-1:0] drift_reg;
    logic                           turning_reg, turn_left_reg, at_target_reg;
    logic signed [PIDSUM_W-1:0]     pid_sum, pid_clamped;

    // result register
    logic                      m_valid_reg;
    logic signed [POWER_W-1:0] left_reg, right_reg;
    logic                      at_reg;
    logic signed [SIDE_W-1:0]  left_q, right_q, pid_side, drift_side;

    always_comb begin
        pid_sum = PIDSUM_W'(beat_i.p_term) + PIDSUM_W'(beat_i.i_term)
                + PIDSUM_W'(beat_i.d_term);
        if (pid_sum > PID_LIM) begin
            pid_clamped = PID_LIM;
        end else if (pid_sum < -PID_LIM) begin
            pid_clamped = -PID_LIM;
        end else begin
            pid_clamped = pid_sum;
        end
    end

    always_comb begin
        pid_side   = SIDE_W'(pid_reg);
        drift_side = SIDE_W'(drift_reg);
        if (turning_reg) begin
            left_q  = turn_left_reg ? -pid_side : pid_side;
            right_q = turn_left_reg ? pid_side : -pid_side;
        end else begin
            left_q  = pid_side + drift_side;
            right_q = pid_side - drift_side;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (adv) begin
            pid_valid_reg <= valid_i;
            m_valid_reg   <= pid_valid_reg;
        end
        if (adv) begin
            pid_reg       <= pid_clamped[PID_W-1:0];
            drift_reg     <= beat_i.drift;
            turning_reg   <= beat_i.turning;
            turn_left_reg <= beat_i.turn_left;
            at_target_reg <= beat_i.at_target;
            left_reg      <= to_power(left_q);
            right_reg     <= to_power(right_q);
            at_reg        <= at_target_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_power  = left_reg;
    assign m_right_power = right_reg;
    assign m_at_target   = at_reg;

endmodule

/* rtl/pid_drive_turn_controller.sv */
// pid_drive_turn_controller: top level with configuration registers and pipeline control;
// depends on pdtc_pkg, pdtc_clamp_div, pdtc_error_stage, pdtc_product_stage, pdtc_mix_stage
`timescale 1ns / 1ps

// One beat in on s_ (restart, primary and secondary sensor) gives one beat out on m_
// (left and right power, at-target flag). Both channels use valid/ready.
// Registers are written through cfg_wr_en / cfg_index / cfg_wdata with no wait; the user
// must write them only while no beat is in flight, which the block does not enforce.
// An accepted input beat is registered in order on its way to m_valid: error and
// integral update at the edge that accepts it, then gain products, pid sum and clamp,
// then side mixing into the result register.
// Throughput is one beat per cycle; the pipeline advances whenever the result register is
// empty or being taken, so a stall on m_ready holds every stage and drops s_ready.
// The integral bound floor((integral_limit << 20) / gain_i) comes from a bit-serial divider;
// it runs after reset and after every write of gain_i or integral_limit, and s_ready stays
// low while it runs.
// Reset loads the default gains, clears the integral sum, the last error and all valids.
module pid_drive_turn_controller
    import pdtc_pkg::*;
#(
    parameter int MAX_DRIVE = MAX_DRIVE_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    input  logic signed [SENSOR_W-1:0]  s_primary_sensor,
    input  logic signed [SENSOR_W-1:0]  s_secondary_sensor,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [POWER_W-1:0]   m_left_power,
    output logic signed [POWER_W-1:0]   m_right_power,
    output logic                        m_at_target
);

    cfg_t cfg_reg;
    logic div_start_reg;
    logic div_busy;
    logic [QUOT_W-1:0] clamp_quot;
    logic adv, accept;
    logic       err_valid, prod_valid;
    err_beat_t  err_beat;
    prod_beat_t prod_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= MODE_RESET;
            cfg_reg.target     <= TARGET_RESET;
            cfg_reg.gain_p     <= GAIN_P_RESET;
            cfg_reg.gain_i     <= GAIN_I_RESET;
            cfg_reg.gain_d     <= GAIN_D_RESET;
            cfg_reg.gain_drift <= GAIN_DRIFT_RESET;
            cfg_reg.ilimit     <= ILIMIT_RESET;
            div_start_reg      <= 1'b1;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MODE:       cfg_reg.mode <= cfg_wdata[MODE_W-1:0];
                    CFG_TARGET:     cfg_reg.target <= cfg_wdata[SENSOR_W-1:0];
                    CFG_GAIN_P:     cfg_reg.gain_p <= cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_I: begin
                        cfg_reg.gain_i <= cfg_wdata[GAIN_W-1:0];
                        div_start_reg  <= 1'b1;
                    end
                    CFG_GAIN_D:     cfg_reg.gain_d <= cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_DRIFT: cfg_reg.gain_drift <= cfg_wdata[GAIN_W-1:0];
                    CFG_ILIMIT: begin
                        cfg_reg.ilimit <= cfg_wdata[LIMIT_W-1:0];
                        div_start_reg  <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && !div_busy && !div_start_reg;
    assign accept  = s_valid && s_ready;

    pdtc_clamp_div u_clamp_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .limit    (cfg_reg.ilimit),
        .gain     (cfg_reg.gain_i),
        .busy     (div_busy),
        .quotient (clamp_quot)
    );

    pdtc_error_stage u_error_stage (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .adv                (adv),
        .accept             (accept),
        .cfg                (cfg_reg),
        .clamp_quot         (clamp_quot),
        .s_restart          (s_restart),
        .s_primary_sensor   (s_primary_sensor),
        .s_secondary_sensor (s_secondary_sensor),
        .valid_o            (err_valid),
        .beat_o             (err_beat)
    );

    pdtc_product_stage u_product_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg_reg),
        .valid_i (err_valid),
        .beat_i  (err_beat),
        .valid_o (prod_valid),
        .beat_o  (prod_beat)
    );

    pdtc_mix_stage #(
        .MAX_DRIVE (MAX_DRIVE)
    ) u_mix_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .valid_i       (prod_valid),
        .beat_i        (prod_beat),
        .m_valid       (m_valid),
        .m_left_power  (m_left_power),
        .m_right_power (m_right_power),
        .m_at_target   (m_at_target)
    );

endmodule

/* tb/pid_drive_turn_controller_tb.sv */
// pid_drive_turn_controller_tb: self-checking bench for the pid drive/turn controller,
// a built-in tick predictor checks every result beat; depends on pdtc_pkg and the rtl top
`timescale 1ns / 1ps

module pid_drive_turn_controller_tb;
    import pdtc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 16;
    localparam int IDLE_PCT = 29;
    localparam int GROW_TICKS = 100;
    localparam longint FRAC_ONE = 64'sd1 <<< FRAC_BITS;
    localparam longint ISUM_MAX = 64'sd2147483647;
    localparam longint ISUM_MIN = -64'sd2147483648;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic signed [POWER_W-1:0] left_power;
        logic signed [POWER_W-1:0] right_power;
        logic                      at_target;
    } power_beat_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_restart;
    logic signed [SENSOR_W-1:0] s_primary_sensor;
    logic signed [SENSOR_W-1:0] s_secondary_sensor;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [POWER_W-1:0]  m_left_power;
    logic signed [POWER_W-1:0]  m_right_power;
    logic                       m_at_target;

    cfg_t        ctl_regs;
    longint      integral_acc;
    longint      last_error;
    power_beat_t pending_powers[$];
    power_beat_t due_beat;
    int          fail_count = 0;
    int          cycle_count = 0;
    logic        quiet_run;

    pid_drive_turn_controller DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_restart         (s_restart),
        .s_primary_sensor  (s_primary_sensor),
        .s_secondary_sensor(s_secondary_sensor),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_power      (m_left_power),
        .m_right_power     (m_right_power),
        .m_at_target       (m_at_target)
    );

    always #2 aclk = ~aclk;

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [SENSOR_W-1:0] to_sensor(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // one control tick: integral zone, integral clamp, pid sum, side mixing
    function automatic power_beat_t predict_powers(input logic restart,
                                                   input logic signed [SENSOR_W-1:0] prim_in,
                                                   input logic signed [SENSOR_W-1:0] sec_in);
        longint      prim, sec, tgt, sensed, err, sum, deriv, pid, lq, rq;
        longint      gp, gi, gd, gdr, ilim_q;
        logic        turning;
        power_beat_t beat;
        prim = prim_in;
        sec = sec_in;
        tgt = ctl_regs.target;
        gp = ctl_regs.gain_p;
        gi = ctl_regs.gain_i;
        gd = ctl_regs.gain_d;
        gdr = ctl_regs.gain_drift;
        ilim_q = ctl_regs.ilimit;
        ilim_q = ilim_q * FRAC_ONE;
        turning = (ctl_regs.mode == MODE_TURN_LEFT) || (ctl_regs.mode == MODE_TURN_RIGHT);
        sensed = (turning && prim < 0) ? -prim : prim;
        err = tgt - sensed;
        if (restart) begin
            integral_acc = 0;
            last_error = 0;
        end
        sum = integral_acc;
        if (turning) begin
            if (8 * err < tgt) sum += err;
            else if (8 * err > tgt) sum = 0;
        end else if ((err < 0 ? -8 * err : 8 * err) < tgt) begin
            sum += err;
        end else begin
            sum = 0;
        end
        if (sum > ISUM_MAX) sum = ISUM_MAX;
        if (sum < ISUM_MIN) sum = ISUM_MIN;
        if (gi != 0) begin
            if (gi * sum > ilim_q) sum = ilim_q / gi;
            else if (gi * sum < -ilim_q) sum = -(ilim_q / gi);
        end
        integral_acc = sum;
        deriv = err - last_error;
        last_error = err;
        pid = clamp_mag(gp * err + gi * sum + gd * deriv, MAX_DRIVE_DEFAULT * FRAC_ONE);
        if (ctl_regs.mode == MODE_TURN_LEFT) begin
            lq = -pid;
            rq = pid;
        end else if (ctl_regs.mode == MODE_TURN_RIGHT) begin
            lq = pid;
            rq = -pid;
        end else begin
            lq = pid + gdr * (prim - sec);
            rq = pid - gdr * (prim - sec);
        end
        beat.left_power = POWER_W'(clamp_mag(lq / FRAC_ONE, POWER_LIMIT));
        beat.right_power = POWER_W'(clamp_mag(rq / FRAC_ONE, POWER_LIMIT));
        beat.at_target = (sensed == tgt);
        return beat;
    endfunction

    task automatic send_tick(input logic restart, input logic signed [SENSOR_W-1:0] prim,
                             input logic signed [SENSOR_W-1:0] sec);
        @(negedge aclk);
        while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        s_primary_sensor <= prim;
        s_secondary_sensor <= sec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_powers.push_back(predict_powers(restart, prim, sec));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_MODE:       ctl_regs.mode = value[MODE_W-1:0];
            CFG_TARGET:     ctl_regs.target = value[SENSOR_W-1:0];
            CFG_GAIN_P:     ctl_regs.gain_p = value[GAIN_W-1:0];
            CFG_GAIN_I:     ctl_regs.gain_i = value[GAIN_W-1:0];
            CFG_GAIN_D:     ctl_regs.gain_d = value[GAIN_W-1:0];
            CFG_GAIN_DRIFT: ctl_regs.gain_drift = value[GAIN_W-1:0];
            CFG_ILIMIT:     ctl_regs.ilimit = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_regs(input logic [MODE_W-1:0] mode, input logic signed [SENSOR_W-1:0] tgt,
                              input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                              input logic [GAIN_W-1:0] gd, input logic [GAIN_W-1:0] gdr,
                              input logic [LIMIT_W-1:0] lim);
        wait_idle();
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_TARGET, {8'd0, tgt});
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_GAIN_DRIFT, gdr);
        write_reg(CFG_ILIMIT, CFG_DATA_W'(lim));
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0, 16'sd0, 16'sd0);
        send_tick(1'b1, 16'sh7FFF, 16'sh8000);
        send_tick(1'b0, 16'sh8000, 16'sh7FFF);
    endtask

    // inside the zone, at target, leaving the zone
    task automatic test_drive_zone();
        apply_regs(MODE_DRIVE, 16'sd4000, 24'd104858, 24'd1000, 24'd50000, 24'd524288, 7'd127);
        send_tick(1'b1, 16'sd3600, 16'sd3590);
        send_tick(1'b0, 16'sd3700, 16'sd3720);
        send_tick(1'b0, 16'sd4000, 16'sd4000);
        send_tick(1'b0, 16'sd4600, 16'sd4500);
        send_tick(1'b0, 16'sd3900, 16'sd3950);
    endtask

    // magnitude of the gyro, zone edge kept, secondary ignored
    task automatic test_turn_modes();
        apply_regs(MODE_TURN_LEFT, 16'sd800, 24'd200000, 24'd3000, 24'd80000, 24'd524288,
                   7'd40);
        send_tick(1'b1, -16'sd700, 16'sd5);
        send_tick(1'b0, 16'sd750, -16'sd300);
        send_tick(1'b0, -16'sd700, 16'sd0);
        send_tick(1'b0, -16'sd800, 16'sd0);
        send_tick(1'b0, 16'sd1000, 16'sd77);
        apply_regs(MODE_TURN_RIGHT, 16'sd800, 24'd200000, 24'd3000, 24'd80000, 24'd524288,
                   7'd40);
        send_tick(1'b0, 16'sd700, 16'sd0);
        send_tick(1'b0, 16'sh8000, 16'sd0);
        send_tick(1'b0, 16'sd0, 16'sd12345);
    endtask

    task automatic test_spare_mode();
        apply_regs(MODE_SPARE, 16'sd100, 24'd104858, 24'd10, 24'd0, 24'd524288, 7'd50);
        send_tick(1'b1, 16'sd90, 16'sd80);
        send_tick(1'b0, 16'sd100, 16'sd100);
    endtask

    // gains at both ends, zero integral limit, zero integral gain
    task automatic test_gain_extremes();
        apply_regs(MODE_DRIVE, 16'sh8000, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 7'd127);
        send_tick(1'b1, 16'sh7FFF, 16'sh8000);
        send_tick(1'b0, 16'sh8000, 16'sh7FFF);
        apply_regs(MODE_DRIVE, 16'sh7FFF, GAIN_MAX, GAIN_MAX, 24'd0, 24'd0, 7'd0);
        send_tick(1'b0, 16'sd32000, 16'sd31000);
        apply_regs(MODE_TURN_LEFT, 16'sh7FFF, 24'd0, 24'd0, 24'd0, 24'd0, 7'd127);
        send_tick(1'b0, 16'sd32000, 16'sd0);
    endtask

    // grow a large negative integral sum with zero gain, then expose it
    task automatic test_integral_growth();
        quiet_run = 1'b1;
        apply_regs(MODE_TURN_RIGHT, 16'sh8000, 24'd0, 24'd0, 24'd0, 24'd0, 7'd127);
        send_tick(1'b1, 16'sh8000, 16'sd0);
        for (int k = 0; k < GROW_TICKS; k++) send_tick(1'b0, 16'sh8000, 16'sd0);
        apply_regs(MODE_TURN_RIGHT, 16'sh8000, 24'd0, 24'd1, 24'd0, 24'd0, 7'd127);
        send_tick(1'b0, 16'sh8000, 16'sd0);
        send_tick(1'b0, 16'sh7FFF, 16'sd0);
        quiet_run = 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return GAIN_MAX;
            2: return 24'($urandom);
            default: return 24'($urandom_range(1 << 18));
        endcase
    endfunction

    // runs of ticks converging on the target, mixed with noise ticks
    task automatic test_random_sequences(input int n_phases, input int per_phase);
        logic [MODE_W-1:0]          mode;
        logic signed [SENSOR_W-1:0] tgt;
        logic signed [SENSOR_W-1:0] prim;
        int                         sent;
        int                         run_len;
        int                         off;
        for (int phase = 0; phase < n_phases; phase++) begin
            mode = MODE_W'($urandom_range(2));
            tgt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(50, 8000));
            apply_regs(mode, tgt, pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                       7'($urandom_range(127)));
            quiet_run = (phase == 3);
            sent = 0;
            while (sent < per_phase) begin
                run_len = $urandom_range(8, 40);
                off = int'($urandom_range(4000)) - 2000;
                for (int k = 0; k < run_len && sent < per_phase; k++) begin
                    if ($urandom_range(3) == 0) begin
                        send_tick($urandom_range(19) == 0, 16'($urandom), 16'($urandom));
                    end else begin
                        prim = to_sensor(int'(tgt) - off);
                        if (mode != MODE_DRIVE && $urandom_range(1)) prim = to_sensor(-int'(prim));
                        send_tick(k == 0, prim,
                                  to_sensor(int'(prim) + int'($urandom_range(20)) - 10));
                        off = off * 3 / 4 + int'($urandom_range(6)) - 3;
                    end
                    sent++;
                end
            end
        end
        quiet_run = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_powers.size() == 0) begin
                fail_count++;
                $error("result beat with no tick outstanding");
            end else begin
                due_beat = pending_powers.pop_front();
                if (m_left_power !== due_beat.left_power) begin
                    fail_count++;
                    $error("left_power: expected %0d, got %0d",
                           due_beat.left_power, m_left_power);
                end
                if (m_right_power !== due_beat.right_power) begin
                    fail_count++;
                    $error("right_power: expected %0d, got %0d",
                           due_beat.right_power, m_right_power);
                end
                if (m_at_target !== due_beat.at_target) begin
                    fail_count++;
                    $error("at_target: expected %0d, got %0d",
                           due_beat.at_target, m_at_target);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_restart = 1'b0;
        s_primary_sensor = '0;
        s_secondary_sensor = '0;
        m_ready = 1'b0;
        quiet_run = 1'b0;
        ctl_regs.mode = MODE_RESET;
        ctl_regs.target = TARGET_RESET;
        ctl_regs.gain_p = GAIN_P_RESET;
        ctl_regs.gain_i = GAIN_I_RESET;
        ctl_regs.gain_d = GAIN_D_RESET;
        ctl_regs.gain_drift = GAIN_DRIFT_RESET;
        ctl_regs.ilimit = ILIMIT_RESET;
        integral_acc = 0;
        last_error = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_drive_zone();
        test_turn_modes();
        test_spare_mode();
        test_gain_extremes();
        test_integral_growth();
        test_random_sequences(10, 112);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
